// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the text tile layer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset
`define TTL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge out of reset
`define TTL_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/ttl_pkg.sv -----
// Shared types and constants for the text tile layer pixel generator
package ttl_pkg;

	localparam int TILE_RAM_DEPTH  = 2048;
	localparam int TILE_BANK_DEPTH = TILE_RAM_DEPTH / 2;
	localparam int TILE_BANK_AW    = $clog2(TILE_BANK_DEPTH);
	localparam int GLYPH_DEPTH     = 4096;
	localparam int GLYPH_AW        = $clog2(GLYPH_DEPTH);
	localparam int OUTQ_DEPTH      = 4;
	localparam int OUTQ_PW         = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CW         = $clog2(OUTQ_DEPTH + 1);

	localparam logic [2:0] PEN_TRANSPARENT = 3'h7;

	typedef enum logic [1:0] {
		OP_TILE_WR  = 2'd0,
		OP_GLYPH_WR = 2'd1,
		OP_FRAME    = 2'd2,
		OP_RENDER   = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  pixel_x;
		logic [7:0]  pixel_y;
		logic [11:0] write_address;
		logic [7:0]  write_data;
	} in_beat_t;

	typedef struct packed {
		logic       opaque;
		logic [3:0] palette_idx;
	} out_beat_t;

	// Fetch pipeline output toward the pixel stage
	typedef struct packed {
		logic       valid;
		op_t        op;
		logic [3:0] px;
		logic [7:0] attr;
		logic [7:0] glyph;
	} pix_t;

endpackage

// ----- rtl/text_tile_layer_pixel_gen_unit.sv -----
// Top level of the text tile layer pixel generator
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  input   | in_valid / in_ready  | in_data  (opcode, pixel, write addr/data)
//  output  | out_valid / out_ready| out_data (opaque, palette_idx)
//
// One input beat per cycle while in_ready is high; a render beat passes a tile RAM
// read, then a glyph store read, then pen select into the result queue.
// in_ready drops only when four render results are pending, set by the
// four-entry result queue; writes and frame starts take no slot.
// Reset clears pipeline valids, queue, glyph registers and attribute latch;
// tile RAM and glyph store contents are not reset.
module text_tile_layer_pixel_gen_unit
	import ttl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data
);

	logic      acc, render_acc, push;
	pix_t      pix;
	out_beat_t res;

	assign acc        = in_valid && in_ready;
	assign render_acc = acc && op_t'(in_data.opcode) == OP_RENDER;

	ttl_fetch u_fetch (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.beat   (in_data),
		.pix    (pix)
	);

	ttl_pixel u_pixel (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.push   (push),
		.res    (res)
	);

	ttl_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.render_acc (render_acc),
		.push       (push),
		.res        (res),
		.credit_ok  (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

// ----- rtl/ttl_ram.sv -----
// Generic simple dual-port RAM, one write port, one registered read port
module ttl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/ttl_fetch.sv -----
// Tile RAM and glyph store fetch pipeline
`include "assert_macros.svh"
module ttl_fetch
	import ttl_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     acc,
	input  in_beat_t beat,
	output pix_t     pix
);

	logic                    tile_even_we, tile_odd_we, glyph_we;
	logic [TILE_BANK_AW-1:0] tile_raddr;
	logic [7:0]              code_rd, attr_rd, glyph_rd;
	logic [GLYPH_AW-1:0]     glyph_raddr;
	op_t                     op_in;

	logic       valid_s1, valid_s2;
	op_t        op_s1, op_s2;
	logic [3:0] px_s1, px_s2;
	logic [2:0] py_s1;
	logic [7:0] attr_s2;

	assign op_in        = op_t'(beat.opcode);
	assign tile_even_we = acc && op_in == OP_TILE_WR && !beat.write_address[0];
	assign tile_odd_we  = acc && op_in == OP_TILE_WR && beat.write_address[0];
	assign glyph_we     = acc && op_in == OP_GLYPH_WR;
	assign tile_raddr   = {beat.pixel_y[7:3], beat.pixel_x[7:3]};

	// code bytes live at even addresses, attributes at odd ones
	ttl_ram #(.WIDTH(8), .DEPTH(TILE_BANK_DEPTH)) u_tile_even (
		.clk   (clk),
		.we    (tile_even_we),
		.waddr (beat.write_address[TILE_BANK_AW:1]),
		.wdata (beat.write_data),
		.raddr (tile_raddr),
		.rdata (code_rd)
	);

	ttl_ram #(.WIDTH(8), .DEPTH(TILE_BANK_DEPTH)) u_tile_odd (
		.clk   (clk),
		.we    (tile_odd_we),
		.waddr (beat.write_address[TILE_BANK_AW:1]),
		.wdata (beat.write_data),
		.raddr (tile_raddr),
		.rdata (attr_rd)
	);

	assign glyph_raddr = {code_rd, py_s1, px_s1[2]};

	ttl_ram #(.WIDTH(8), .DEPTH(GLYPH_DEPTH)) u_glyph (
		.clk   (clk),
		.we    (glyph_we),
		.waddr (beat.write_address[GLYPH_AW-1:0]),
		.wdata (beat.write_data),
		.raddr (glyph_raddr),
		.rdata (glyph_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= acc && (op_in == OP_FRAME || op_in == OP_RENDER);
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s1   <= op_in;
		px_s1   <= beat.pixel_x[3:0];
		py_s1   <= beat.pixel_y[2:0];
		op_s2   <= op_s1;
		px_s2   <= px_s1;
		attr_s2 <= attr_rd;
	end

	assign pix.valid = valid_s2;
	assign pix.op    = op_s2;
	assign pix.px    = px_s2;
	assign pix.attr  = attr_s2;
	assign pix.glyph = glyph_rd;

	`TTL_ASSERT(a_s2_follows_s1, valid_s2 |-> $past(valid_s1), "s2 valid without s1")
	`TTL_NEVER(a_s1_no_write_op,
		valid_s1 && (op_s1 == OP_TILE_WR || op_s1 == OP_GLYPH_WR),
		"memory write reached the pixel pipeline")

endmodule

// ----- rtl/ttl_pixel.sv -----
// Glyph registers, attribute latch and pen selection
`include "assert_macros.svh"
module ttl_pixel
	import ttl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  pix_t      pix,
	output logic      push,
	output out_beat_t res
);

	logic [7:0] regs_q [4];
	logic [7:0] regs_nx [4];
	logic [7:0] latch_q, latch_nx;
	logic [3:0] sum;
	logic [7:0] sel;
	logic [1:0] k;
	logic       c0, c1;
	logic [3:0] col;

	always_comb begin
		latch_nx = latch_q;
		regs_nx  = regs_q;
		if (pix.valid) begin
			unique case (pix.op)
				OP_FRAME: begin
					latch_nx = '0;
					for (int i = 0; i < 4; i++) regs_nx[i] = '0;
				end
				OP_RENDER: begin
					if (!pix.attr[4] && pix.px[2]) latch_nx = pix.attr;
					regs_nx[pix.px[3:2]] = pix.glyph;
				end
				default: begin
				end
			endcase
		end
	end

	// pen lookup sees this pixel's own register and latch updates
	always_comb begin
		sum = pix.px + latch_nx[3:0];
		sel = regs_nx[sum[3:2]];
		k   = 2'd3 - sum[1:0];
		c0  = sel[{1'b0, k}];
		c1  = sel[{1'b1, k}];
		col = {latch_nx[7:6], c1, c0};
	end

	assign push            = pix.valid && pix.op == OP_RENDER;
	assign res.opaque      = col[2:0] != PEN_TRANSPARENT;
	assign res.palette_idx = (col[2:0] != PEN_TRANSPARENT) ? col : 4'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q <= '0;
			for (int i = 0; i < 4; i++) regs_q[i] <= '0;
		end else begin
			latch_q <= latch_nx;
			regs_q  <= regs_nx;
		end
	end

	`TTL_ASSERT(a_frame_clears_latch, (pix.valid && pix.op == OP_FRAME) |=> latch_q == 8'd0,
		"frame start left attribute latch set")
	`TTL_NEVER(a_transparent_zero, push && !res.opaque && res.palette_idx != 4'd0,
		"transparent pixel with nonzero color")

endmodule

// ----- rtl/ttl_outq.sv -----
// Result queue with credit count covering pixels still in the fetch pipeline
`include "assert_macros.svh"
module ttl_outq
	import ttl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      render_acc,
	input  logic      push,
	input  out_beat_t res,
	output logic      credit_ok,
	output logic      out_valid,
	input  logic      out_ready,
	output out_beat_t out_data
);

	out_beat_t          q_mem [OUTQ_DEPTH];
	logic [OUTQ_PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [OUTQ_CW-1:0] count_q, pend_q;
	logic               pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = count_q != '0;
	assign out_data  = q_mem[rd_ptr_q];
	// every accepted render holds a slot until its beat leaves
	assign credit_ok = pend_q < OUTQ_CW'(OUTQ_DEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			pend_q   <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + OUTQ_CW'(push) - OUTQ_CW'(pop);
			pend_q  <= pend_q + OUTQ_CW'(render_acc) - OUTQ_CW'(pop);
		end
	end

	`TTL_NEVER(a_no_overflow, push && !pop && count_q == OUTQ_CW'(OUTQ_DEPTH),
		"result queue overflow")
	`TTL_ASSERT(a_credit_covers, pend_q >= count_q, "queued beats exceed credits")

endmodule

// ----- dv/text_tile_layer_pixel_gen_unit_test.sv -----
// Self-checking testbench for the text tile layer pixel generator
module text_tile_layer_pixel_gen_unit_test;
	import ttl_pkg::*;

	localparam int HALF_PERIOD    = 10;
	localparam int RESET_CYCLES   = 7;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 10;
	localparam int PHASE_BEATS    = 500;
	localparam int MAX_PRINTS     = 200;

	// Tracks tile RAM, glyph store, glyph registers and the attribute latch,
	// and holds the pixels still owed by the block in arrival order.
	class pixel_scoreboard;
		logic [7:0] tile_mem[TILE_RAM_DEPTH];
		logic [7:0] glyph_mem[GLYPH_DEPTH];
		logic [7:0] glyph_reg[4];
		logic [7:0] attr_latch;
		out_beat_t  pixel_q[$];
		int         errors;
		int         n_checked;
		int         n_clear;
		int         n_frames;

		function new();
			foreach (tile_mem[i]) tile_mem[i] = 8'h00;
			foreach (glyph_mem[i]) glyph_mem[i] = 8'h00;
			clear_frame();
			errors = 0;
			n_checked = 0;
			n_clear = 0;
			n_frames = 0;
		endfunction

		function void clear_frame();
			foreach (glyph_reg[i]) glyph_reg[i] = 8'h00;
			attr_latch = 8'h00;
		endfunction

		function out_beat_t render_pixel(logic [7:0] px, logic [7:0] py);
			logic [10:0] tile_addr;
			logic [7:0]  code;
			logic [7:0]  attr;
			logic [7:0]  sel;
			logic [3:0]  sum;
			logic [1:0]  k;
			logic [3:0]  col;
			out_beat_t   r;
			tile_addr = {py[7:3], px[7:3], 1'b0};
			code = tile_mem[tile_addr];
			attr = tile_mem[tile_addr | 11'd1];
			if (!attr[4] && px[2])
				attr_latch = attr;
			glyph_reg[px[3:2]] = glyph_mem[{code, py[2:0], px[2]}];
			sum = px[3:0] + attr_latch[3:0];
			sel = glyph_reg[sum[3:2]];
			k = 2'd3 - sum[1:0];
			col = {attr_latch[7:6], sel[{1'b1, k}], sel[{1'b0, k}]};
			if (col[2:0] == PEN_TRANSPARENT) begin
				r.opaque = 1'b0;
				r.palette_idx = 4'd0;
			end else begin
				r.opaque = 1'b1;
				r.palette_idx = col;
			end
			return r;
		endfunction

		function void note_beat(in_beat_t b);
			case (b.opcode)
				OP_TILE_WR: tile_mem[b.write_address[10:0]] = b.write_data;
				OP_GLYPH_WR: glyph_mem[b.write_address] = b.write_data;
				OP_FRAME: begin
					clear_frame();
					n_frames++;
				end
				default: pixel_q.push_back(render_pixel(b.pixel_x, b.pixel_y));
			endcase
		endfunction

		task report(string msg);
			if (errors < MAX_PRINTS)
				$display("MISMATCH: %s", msg);
			errors++;
		endtask

		task check_pixel(out_beat_t got);
			out_beat_t want;
			if (pixel_q.size() == 0) begin
				report($sformatf("pixel beat with none pending: opaque=%0b color=%0d",
					got.opaque, got.palette_idx));
				return;
			end
			want = pixel_q.pop_front();
			n_checked++;
			if (!want.opaque)
				n_clear++;
			if (got.opaque !== want.opaque)
				report($sformatf("pixel %0d opaque: got %0b, want %0b",
					n_checked, got.opaque, want.opaque));
			if (got.palette_idx !== want.palette_idx)
				report($sformatf("pixel %0d palette_idx: got %0d, want %0d",
					n_checked, got.palette_idx, want.palette_idx));
		endtask
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_beat_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_beat_t out_data;

	pixel_scoreboard sb = new();

	// Stimulus-side view of what has been written, so no render reads an
	// entry that was never loaded.
	logic [7:0] shadow_tile[TILE_RAM_DEPTH];
	bit         tile_known[TILE_RAM_DEPTH];
	bit         glyph_known[GLYPH_DEPTH];
	int         n_sent = 0;
	int         sender_idle_pct = 0;
	int         receiver_stall_pct = 0;
	int         idle_count = 0;

	text_tile_layer_pixel_gen_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_pixel(out_data);
			if (in_valid && in_ready)
				sb.note_beat(in_data);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
			$display("text_tile_layer_pixel_gen_unit_test failed");
			$finish;
		end
	end

	// Valid stays up between back-to-back beats; it drops only for a gap.
	task send_beat(in_beat_t b);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		n_sent++;
	endtask

	task put_tile(logic [11:0] addr, logic [7:0] data);
		in_beat_t b;
		b.opcode = OP_TILE_WR;
		b.pixel_x = 8'($urandom);
		b.pixel_y = 8'($urandom);
		b.write_address = addr;
		b.write_data = data;
		send_beat(b);
		shadow_tile[addr[10:0]] = data;
		tile_known[addr[10:0]] = 1'b1;
	endtask

	task put_glyph(logic [11:0] addr, logic [7:0] data);
		in_beat_t b;
		b.opcode = OP_GLYPH_WR;
		b.pixel_x = 8'($urandom);
		b.pixel_y = 8'($urandom);
		b.write_address = addr;
		b.write_data = data;
		send_beat(b);
		glyph_known[addr] = 1'b1;
	endtask

	task start_frame();
		in_beat_t b;
		b.opcode = OP_FRAME;
		b.pixel_x = 8'($urandom);
		b.pixel_y = 8'($urandom);
		b.write_address = 12'($urandom);
		b.write_data = 8'($urandom);
		send_beat(b);
	endtask

	// Loads whatever the pixel will read if it is still unwritten, then renders.
	task draw(logic [7:0] px, logic [7:0] py);
		in_beat_t    b;
		logic [10:0] tile_addr;
		logic [11:0] addr;
		tile_addr = {py[7:3], px[7:3], 1'b0};
		addr = 12'($urandom);
		if (!tile_known[tile_addr]) begin
			addr[10:0] = tile_addr;
			put_tile(addr, 8'($urandom));
		end
		if (!tile_known[tile_addr | 11'd1]) begin
			addr[10:0] = tile_addr | 11'd1;
			put_tile(addr, 8'($urandom));
		end
		addr = {shadow_tile[tile_addr], py[2:0], px[2]};
		if (!glyph_known[addr])
			put_glyph(addr, 8'($urandom));
		b.opcode = OP_RENDER;
		b.pixel_x = px;
		b.pixel_y = py;
		b.write_address = 12'($urandom);
		b.write_data = 8'($urandom);
		send_beat(b);
	endtask

	// Sender holds off until the block has delivered every pending pixel.
	task drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pixel_q.size() != 0)
			@(posedge clk);
	endtask

	task run_phase(int idle_pct, int stall_pct);
		int goal;
		int pick;
		int x0;
		int y0;
		int len;
		int rows;
		goal = n_sent + PHASE_BEATS;
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		while (n_sent < goal) begin
			pick = $urandom_range(99);
			if (pick < 65) begin
				// raster span: a few consecutive rows of one horizontal run
				if ($urandom_range(3) == 0)
					start_frame();
				x0 = $urandom_range(255);
				y0 = $urandom_range(255);
				len = $urandom_range(4, 32);
				rows = $urandom_range(1, 3);
				for (int r = 0; r < rows && y0 + r < 256; r++)
					for (int i = 0; i < len && x0 + i < 256; i++)
						draw(8'(x0 + i), 8'(y0 + r));
			end else if (pick < 75) begin
				repeat ($urandom_range(1, 4)) put_tile(12'($urandom), 8'($urandom));
			end else if (pick < 85) begin
				repeat ($urandom_range(1, 4)) put_glyph(12'($urandom), 8'($urandom));
			end else if (pick < 93) begin
				// out-of-order pixels
				repeat ($urandom_range(1, 4)) draw(8'($urandom), 8'($urandom));
			end else begin
				start_frame();
			end
		end
		drain();
	endtask

	initial begin
		foreach (shadow_tile[i]) shadow_tile[i] = 8'h00;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: address wrap on tile writes, both ends of the raster,
		// attribute with and without latch load, and a transparent run.
		put_tile(12'h000, 8'h00);
		put_tile(12'h801, 8'h27);
		put_tile(12'hffe, 8'hff);
		put_tile(12'hfff, 8'h4f);
		put_glyph(12'h000, 8'ha5);
		put_glyph(12'h001, 8'h3c);
		put_glyph(12'hffe, 8'hff);
		put_glyph(12'hfff, 8'hff);
		start_frame();
		for (int x = 0; x < 6; x++)
			draw(8'(x), 8'd0);
		start_frame();
		for (int x = 248; x < 256; x++)
			draw(8'(x), 8'd255);
		drain();

		run_phase(0, 0);
		run_phase(83, 0);
		run_phase(0, 83);
		run_phase(25, 25);

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("%0d beats driven, %0d pixels checked (%0d transparent), %0d frame starts",
			n_sent, sb.n_checked, sb.n_clear, sb.n_frames);
		$display("pacing: free-running, sender gaps, receiver stalls, and both together");
		if (sb.errors == 0 && sb.pixel_q.size() == 0) begin
			$display("text_tile_layer_pixel_gen_unit_test passed");
		end else begin
			$display("%0d mismatches, %0d pixels outstanding", sb.errors, sb.pixel_q.size());
			$display("text_tile_layer_pixel_gen_unit_test failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/ttl_pkg.sv
rtl/ttl_ram.sv
rtl/ttl_fetch.sv
rtl/ttl_pixel.sv
rtl/ttl_outq.sv
rtl/text_tile_layer_pixel_gen_unit.sv
dv/text_tile_layer_pixel_gen_unit_test.sv
